@@ src/scba_pkg.sv @@
// Shared types, constants and codes of the size-class block allocator.
// No dependencies; imported by the controller, the datapath and the top level.

package scba_pkg;

    // Defaults for the top-level parameters
    localparam int ADDR_WIDTH_DEF     = 32;
    localparam int NUM_CLASSES_DEF    = 19;
    localparam int STACK_DEPTH_DEF    = 256;
    localparam int MIN_CLASS_LOG2_DEF = 4;

    // Fixed field widths
    localparam int DATA_W     = 32;   // stored block address, granted address
    localparam int SIZE_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int PAGE_W     = 4;
    localparam int HDR_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Largest value the page_log2 register can hold
    localparam int PAGE_LOG_MAX = 15;

    // Register reset values
    localparam logic [PAGE_W-1:0] PAGE_LOG2_RST    = PAGE_W'(12);
    localparam logic [DATA_W-1:0] HEAP_BASE_RST    = '0;
    localparam logic [DATA_W-1:0] HEAP_LIMIT_RST   = '1;
    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = HDR_W'(32);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL     = 3'd4;

    // Request kind
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Source of the granted address in the result beat
    typedef enum logic [1:0] {
        GRANT_ZERO = 2'd0,
        GRANT_POP  = 2'd1,
        GRANT_FILL = 2'd2
    } grant_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic                load_req;    // capture the accepted request
        logic                load_cls;    // register class and size check
        logic                push_free;   // push the freed address
        logic                pop_rd;      // read the stack top and pop it
        logic                start_fill;  // carve a region, set up the fill
        logic                fill_step;   // push one block of the region
        logic                load_out;    // load the result register
        grant_sel_t          grant_sel;
        logic [STATUS_W-1:0] status;
    } scba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic func;
        logic addr_zero;
        logic bad_size;
        logic cnt_zero;
        logic cnt_full;
        logic oom;
        logic fill_last;
    } scba_stat_t;

endpackage

@@ src/scba_ctrl.sv @@
// Sequencing controller of the size-class block allocator.
// Depends on scba_pkg for the command and status structs and the codes.

module scba_ctrl
    import scba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  scba_stat_t stat,
    output scba_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLASS  = 6'b000010,
        S_DECIDE = 6'b000100,
        S_CHECK  = 6'b001000,
        S_FILL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    grant_sel_t          sel_reg, sel_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        sel_next       = sel_reg;
        cmd            = '0;
        cmd.grant_sel  = sel_reg;
        cmd.status     = status_reg;

        // drop the result once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CLASS;
                end
            end
            S_CLASS:
            begin
                cmd.load_cls = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                sel_next   = GRANT_ZERO;
                state_next = S_FINISH;
                if (stat.func == FUNC_FREE)
                begin
                    priority if (stat.addr_zero)
                    begin
                        status_next = ST_NULL;
                    end
                    else if (stat.bad_size)
                    begin
                        status_next = ST_BAD_SIZE;
                    end
                    else if (stat.cnt_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.push_free = 1'b1;
                        status_next   = ST_OK;
                    end
                end
                else
                begin
                    priority if (stat.bad_size)
                    begin
                        status_next = ST_BAD_SIZE;
                    end
                    else if (stat.cnt_zero)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.pop_rd  = 1'b1;
                        status_next = ST_OK;
                        sel_next    = GRANT_POP;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.oom)
                begin
                    status_next = ST_OOM;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.start_fill = 1'b1;
                    state_next     = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    status_next = ST_OK;
                    sel_next    = GRANT_FILL;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
            sel_reg     <= GRANT_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            sel_reg     <= sel_next;
        end
    end

endmodule

@@ src/scba_datapath.sv @@
// Datapath of the size-class block allocator: configuration, class lookup,
// free stack memory and counts, bump pointer, refill sequencing, result register.
// Depends on scba_pkg.

module scba_datapath
    import scba_pkg::*;
#(
    parameter int ADDR_WIDTH     = ADDR_WIDTH_DEF,
    parameter int NUM_CLASSES    = NUM_CLASSES_DEF,
    parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
    parameter int MIN_CLASS_LOG2 = MIN_CLASS_LOG2_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_func,
    input  logic [SIZE_W-1:0]     in_size,
    input  logic [DATA_W-1:0]     in_addr,
    input  scba_cmd_t             cmd,
    output scba_stat_t            stat,
    output logic [DATA_W-1:0]     out_addr,
    output logic [STATUS_W-1:0]   out_status
);

    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CC_W    = $clog2(NUM_CLASSES + 1);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int MEM_D   = NUM_CLASSES * STACK_DEPTH;
    localparam int MEM_AW  = $clog2(MEM_D);
    localparam int TOP_LOG = MIN_CLASS_LOG2 + NUM_CLASSES - 1;
    localparam int MAXLOG  = (TOP_LOG > PAGE_LOG_MAX) ? TOP_LOG : PAGE_LOG_MAX;
    localparam int LOG_W   = $clog2(MAXLOG + 1);
    localparam int BW      = (ADDR_WIDTH > DATA_W) ? ADDR_WIDTH : DATA_W;
    localparam int CW      = ((BW > MAXLOG + 1) ? BW : MAXLOG + 1) + 2;
    localparam int NB_W    = ((PAGE_LOG_MAX + 1 > CNT_W) ? PAGE_LOG_MAX + 1 : CNT_W) + 1;
    localparam int CMP_W   = 2 * SIZE_W;

    localparam logic [BW-1:0] AMASK = BW'((CW'(1) << ADDR_WIDTH) - CW'(1));

    // Configuration registers
    logic [PAGE_W-1:0] page_log2_reg;
    logic [DATA_W-1:0] heap_limit_reg;
    logic [HDR_W-1:0]  header_bytes_reg;

    // Request and working registers
    logic              func_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [DATA_W-1:0] addr_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic              bad_reg;
    logic [BW-1:0]     bump_reg;
    logic [CW-1:0]     total_reg;
    logic [CW-1:0]     blk_reg;
    logic [CNT_W-1:0]  fill_n_reg;
    logic [CNT_W-1:0]  fill_left_reg;
    logic [BW-1:0]     fill_addr_reg;
    logic [DATA_W-1:0] grant_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  counts_reg [NUM_CLASSES];
    logic [DATA_W-1:0] out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [DATA_W-1:0] stack_mem [MEM_D];

    // Combinational values
    logic [CC_W-1:0]   cls_cnt;
    logic [CNT_W-1:0]  cur_cnt;
    logic [LOG_W-1:0]  blk_log;
    logic [LOG_W-1:0]  page_log;
    logic [LOG_W-1:0]  span_log;
    logic [LOG_W-1:0]  fill_shift;
    logic [NB_W-1:0]   nblk;
    logic [CW-1:0]     bump_ext;
    logic [CW-1:0]     end_ext;
    logic [CNT_W-1:0]  slot;
    logic [MEM_AW-1:0] mem_addr;
    logic              mem_we;
    logic [DATA_W-1:0] mem_wdata;

    // Class lookup: count the class sizes the request exceeds
    always_comb
    begin
        cls_cnt = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (CMP_W'(size_reg) > (CMP_W'(1) << (MIN_CLASS_LOG2 + k)))
            begin
                cls_cnt = cls_cnt + CC_W'(1);
            end
        end
    end

    assign cur_cnt = bad_reg ? '0 : counts_reg[cls_reg];

    // Refill plan for the current class
    always_comb
    begin
        blk_log    = LOG_W'(MIN_CLASS_LOG2) + LOG_W'(cls_reg);
        page_log   = LOG_W'(page_log2_reg);
        span_log   = (page_log > blk_log) ? page_log : blk_log;
        fill_shift = (page_log > blk_log) ? (page_log - blk_log) : '0;
        nblk       = NB_W'(1) << fill_shift;
    end

    // Out-of-memory check
    assign bump_ext = CW'(bump_reg);
    assign end_ext  = bump_ext + total_reg - CW'(1);

    // Stack memory port
    always_comb
    begin
        slot      = cmd.pop_rd ? (cur_cnt - CNT_W'(1)) : cur_cnt;
        mem_addr  = MEM_AW'(cls_reg) * MEM_AW'(STACK_DEPTH) + MEM_AW'(slot[IDX_W-1:0]);
        mem_we    = cmd.push_free || cmd.fill_step;
        mem_wdata = cmd.fill_step ? fill_addr_reg[DATA_W-1:0] : addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.pop_rd)
        begin
            rd_data_reg <= stack_mem[mem_addr];
        end
    end

    // Status to controller
    always_comb
    begin
        stat.func      = func_reg;
        stat.addr_zero = (addr_reg == '0);
        stat.bad_size  = bad_reg;
        stat.cnt_zero  = (cur_cnt == '0);
        stat.cnt_full  = (cur_cnt >= CNT_W'(STACK_DEPTH));
        stat.oom       = (bump_ext > CW'(heap_limit_reg)) || (end_ext > CW'(heap_limit_reg));
        stat.fill_last = (fill_left_reg == CNT_W'(1));
    end

    // Configuration, bump pointer and per-class counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_log2_reg    <= PAGE_LOG2_RST;
            heap_limit_reg   <= HEAP_LIMIT_RST;
            header_bytes_reg <= HEADER_BYTES_RST;
            bump_reg         <= BW'(HEAP_BASE_RST);
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                counts_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PAGE_LOG2:    page_log2_reg    <= cfg_wdata[PAGE_W-1:0];
                    CFG_HEAP_BASE:    bump_reg         <= BW'(cfg_wdata[DATA_W-1:0]);
                    CFG_HEAP_LIMIT:   heap_limit_reg   <= cfg_wdata[DATA_W-1:0];
                    CFG_HEADER_BYTES: header_bytes_reg <= cfg_wdata[HDR_W-1:0];
                    default:          ;
                endcase
            end
            // advance the bump pointer past the carved region
            if (cmd.start_fill)
            begin
                bump_reg <= BW'(bump_ext + total_reg) & AMASK;
            end
            // push grows the count, pop shrinks it; the last fill beat is popped
            if (cmd.push_free || (cmd.fill_step && !stat.fill_last))
            begin
                counts_reg[cls_reg] <= cur_cnt + CNT_W'(1);
            end
            else if (cmd.pop_rd)
            begin
                counts_reg[cls_reg] <= cur_cnt - CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= in_func;
            size_reg <= in_size;
            addr_reg <= in_addr;
        end
        if (cmd.load_cls)
        begin
            cls_reg <= CLS_W'(cls_cnt);
            bad_reg <= (cls_cnt == CC_W'(NUM_CLASSES));
        end
        else
        begin
            // plan the refill while the class is decided
            total_reg  <= (CW'(1) << span_log) + CW'(header_bytes_reg);
            blk_reg    <= CW'(1) << blk_log;
            fill_n_reg <= (nblk > NB_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH) : CNT_W'(nblk);
        end
        if (cmd.start_fill)
        begin
            fill_addr_reg <= BW'(bump_ext + CW'(header_bytes_reg)) & AMASK;
            fill_left_reg <= fill_n_reg;
        end
        else if (cmd.fill_step)
        begin
            fill_addr_reg <= BW'(CW'(fill_addr_reg) + blk_reg) & AMASK;
            fill_left_reg <= fill_left_reg - CNT_W'(1);
            grant_reg     <= fill_addr_reg[DATA_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.status;
            unique case (cmd.grant_sel)
                GRANT_POP:  out_addr_reg <= rd_data_reg;
                GRANT_FILL: out_addr_reg <= grant_reg;
                default:    out_addr_reg <= '0;
            endcase
        end
    end

    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

@@ src/size_class_block_allocator.sv @@
// Top level of the power-of-two size-class block allocator.
// Depends on scba_pkg, scba_ctrl and scba_datapath.
//
//   Channel  Direction  Beat contents
//   s_*      in         tuser: func; tdata: size_bytes, block_addr
//   m_*      out        tuser: status; tdata: granted_addr
//   cfg_*    in         cfg_index selects the register, cfg_wdata the value
//
// A request whose class stack is not empty passes accept, class lookup, decision
// and result load in order, then returns to idle. An alloc that finds its stack
// empty adds an out-of-memory check and, if it passes, a fill of n blocks,
// n = min(2^(page_log2 - class log2), STACK_DEPTH) when page_log2 exceeds the
// class log2 and 1 otherwise; the single stack write port takes one push per cycle.
// Reset clears counts and the bump pointer at once; no clearing pass is run.
// A waiting result holds only the final step; the next request is still taken.

module size_class_block_allocator
    import scba_pkg::*;
#(
    parameter int ADDR_WIDTH     = ADDR_WIDTH_DEF,
    parameter int NUM_CLASSES    = NUM_CLASSES_DEF,
    parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
    parameter int MIN_CLASS_LOG2 = MIN_CLASS_LOG2_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [31:0] size_bytes, [63:32] block_addr
    input  logic                  s_tuser,   // [0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] granted_addr
    output logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    scba_cmd_t  cmd;
    scba_stat_t stat;

    scba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scba_datapath #(
        .ADDR_WIDTH     (ADDR_WIDTH),
        .NUM_CLASSES    (NUM_CLASSES),
        .STACK_DEPTH    (STACK_DEPTH),
        .MIN_CLASS_LOG2 (MIN_CLASS_LOG2)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser),
        .in_size    (s_tdata[31:0]),
        .in_addr    (s_tdata[63:32]),
        .cmd        (cmd),
        .stat       (stat),
        .out_addr   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

@@ tb/sv/scba_result_checker.sv @@
// Result checker for the size-class block allocator: mirrors the class stacks,
// bump pointer and registers from the observed beats and checks each result beat.
// Depends on scba_pkg for widths, register indexes and status codes.
`timescale 1ns / 100ps

module scba_result_checker
    import scba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [31:0] size_bytes, [63:32] block_addr
    input  logic                  s_tuser,   // [0] func
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [31:0] granted_addr
    input  logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    results_owed
);

    localparam int CLASSES  = NUM_CLASSES_DEF;
    localparam int DEPTH    = STACK_DEPTH_DEF;
    localparam int MIN_LOG2 = MIN_CLASS_LOG2_DEF;

    typedef struct packed {
        logic [DATA_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic [PAGE_W-1:0] page_log2_q;
    logic [DATA_W-1:0] limit_q;
    logic [HDR_W-1:0]  hdr_q;
    logic [63:0]       bump_q;
    logic [DATA_W-1:0] block_store [CLASSES][DEPTH];
    int unsigned       block_count [CLASSES];
    grant_t            expected_grants [$];

    // Map a byte size to its class, -1 when above the largest class
    function automatic int class_of(logic [31:0] size);
        for (int k = 0; k < CLASSES; k++)
        begin
            if (64'(size) <= (64'd1 << (MIN_LOG2 + k)))
                return k;
        end
        return -1;
    endfunction

    // Push one free block; report false when the class stack is full
    function automatic bit push_block(int cls, logic [63:0] addr);
        if (block_count[cls] >= DEPTH)
            return 1'b0;
        block_store[cls][block_count[cls]] = addr[DATA_W-1:0];
        block_count[cls]++;
        return 1'b1;
    endfunction

    // Carve a region at the bump pointer and stack its blocks, lowest first
    function automatic bit carve_region(int cls);
        logic [63:0]     blk;
        logic [63:0]     page;
        logic [63:0]     span;
        logic [63:0]     total;
        logic [63:0]     first;
        longint unsigned nblk;
        blk   = 64'd1 << (MIN_LOG2 + cls);
        page  = 64'd1 << page_log2_q;
        span  = (page > blk) ? page : blk;
        total = span + 64'(hdr_q);
        if (bump_q > 64'(limit_q) || bump_q + total - 64'd1 > 64'(limit_q))
            return 1'b0;
        first = bump_q + 64'(hdr_q);
        nblk  = span / blk;
        for (longint unsigned i = 0; i < nblk; i++)
        begin
            if (!push_block(cls, first + i * blk))
                break;
        end
        bump_q = (bump_q + total) & 64'hFFFF_FFFF;
        return 1'b1;
    endfunction

    // Work out the result beat of one request and update the mirrored state
    function automatic grant_t predict_grant(logic func, logic [31:0] size,
                                             logic [31:0] addr);
        grant_t r;
        int     cls;
        r.addr   = '0;
        r.status = ST_OK;
        if (func == FUNC_ALLOC)
        begin
            cls = class_of(size);
            if (cls < 0)
                r.status = ST_BAD_SIZE;
            else
            begin
                if (block_count[cls] == 0)
                begin
                    if (!carve_region(cls))
                        r.status = ST_OOM;
                end
                if (r.status == ST_OK)
                begin
                    block_count[cls]--;
                    r.addr = block_store[cls][block_count[cls]];
                end
            end
        end
        else if (addr == '0)
            r.status = ST_NULL;
        else
        begin
            cls = class_of(size);
            if (cls < 0)
                r.status = ST_BAD_SIZE;
            else if (!push_block(cls, 64'(addr)))
                r.status = ST_FULL;
        end
        return r;
    endfunction

    // Track register writes, predict on request beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t want;
        if (!rst_n)
        begin
            page_log2_q = PAGE_LOG2_RST;
            limit_q     = HEAP_LIMIT_RST;
            hdr_q       = HEADER_BYTES_RST;
            bump_q      = 64'(HEAP_BASE_RST);
            for (int k = 0; k < CLASSES; k++)
                block_count[k] = 0;
            expected_grants.delete();
            fail_count   = 0;
            results_owed = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGE_LOG2:    page_log2_q = cfg_wdata[PAGE_W-1:0];
                    CFG_HEAP_BASE:    bump_q = 64'(cfg_wdata);
                    CFG_HEAP_LIMIT:   limit_q = cfg_wdata;
                    CFG_HEADER_BYTES: hdr_q = cfg_wdata[HDR_W-1:0];
                    default: ;
                endcase
            end

            // Compare the result beat against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result beat with none pending: granted_addr %h status %0d",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (m_tdata !== want.addr)
                    begin
                        $error("granted_addr: expected %h, actual %h", want.addr, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        fail_count++;
                    end
                end
            end

            // Predict the result of an accepted request beat
            if (s_tvalid && s_tready)
                expected_grants.push_back(predict_grant(s_tuser, s_tdata[31:0],
                                                        s_tdata[63:32]));
            results_owed = expected_grants.size();
        end
    end

endmodule

@@ tb/sv/tb_size_class_block_allocator.sv @@
// Testbench top for the size-class block allocator: drives request, result and
// register traffic and gives the verdict. Depends on scba_pkg, the block and
// scba_result_checker.
`timescale 1ns / 100ps

module tb_size_class_block_allocator
    import scba_pkg::*;
();

    localparam int LONG_HOLD = 300;

    typedef struct {
        logic        func;
        logic [31:0] size;
    } request_t;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] size;
    } block_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;   // [31:0] size_bytes, [63:32] block_addr
    logic                  s_tuser   = 1'b0; // [0] func
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [31:0] granted_addr
    logic [STATUS_W-1:0]   m_tuser;          // [2:0] status
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    results_owed;

    bit       no_idle  = 1'b0;
    bit       hold_req = 1'b0;
    request_t requests_in_flight [$];
    block_t   live_blocks [$];

    size_class_block_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    scba_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one request beat and hold it until accepted
    task automatic send_item(input logic func, input logic [31:0] size,
                             input logic [31:0] addr);
        while (!no_idle && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {addr, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_in_flight.push_back('{func, size});
        @(negedge clk);
    endtask

    // Stop offering and wait until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Write all four registers back to back
    task automatic set_config(input logic [PAGE_W-1:0] page, input logic [31:0] base,
                              input logic [31:0] limit, input logic [HDR_W-1:0] hdr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_LOG2;
        cfg_wdata <= 32'(page);
        @(negedge clk);
        cfg_index <= CFG_HEAP_BASE;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_index <= CFG_HEAP_LIMIT;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_index <= CFG_HEADER_BYTES;
        cfg_wdata <= 32'(hdr);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pick a byte size in a class range, exact powers of two now and then
    function automatic logic [31:0] pick_size(int lo_k, int hi_k);
        int k;
        k = $urandom_range(hi_k, lo_k);
        if (k == 0)
            return $urandom_range(16, 0);
        if ($urandom_range(3) == 0)
            return 32'd1 << (k + MIN_CLASS_LOG2_DEF);
        return $urandom_range(32'd1 << (k + 4), (32'd1 << (k + 3)) + 1);
    endfunction

    // Mostly alloc and matching free of live blocks, plus noise
    task automatic random_item();
        int     pick;
        int     idx;
        block_t b;
        pick = $urandom_range(99);
        if (pick < 45)
            send_item(FUNC_ALLOC, pick_size(0, 8), $urandom);
        else if (pick < 50)
            send_item(FUNC_ALLOC, pick_size(9, 18), $urandom);
        else if (pick < 80 && live_blocks.size() != 0)
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            b = live_blocks[idx];
            live_blocks.delete(idx);
            send_item(FUNC_FREE, b.size, b.addr);
        end
        else if (pick < 85)
            send_item(FUNC_FREE, $urandom, '0);
        else if (pick < 92)
            send_item(logic'($urandom_range(1)), $urandom_range(32'hFFFF_FFFF, 32'h0040_0001),
                      $urandom);
        else
            send_item(FUNC_FREE, pick_size(0, 8), $urandom);
    endtask

    // Collect granted blocks so later frees hit real addresses
    always @(posedge clk)
    begin : track_grants
        request_t req;
        if (rst_n && m_tvalid && m_tready && requests_in_flight.size() != 0)
        begin
            req = requests_in_flight.pop_front();
            if (req.func == FUNC_ALLOC && m_tuser == ST_OK)
            begin
                live_blocks.push_back('{m_tdata, req.size});
                if (live_blocks.size() > 400)
                    void'(live_blocks.pop_front());
            end
        end
    end

    // Result side: random stalls, one long hold on request
    initial
    begin : sink
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= 16);
        end
    end

    initial
    begin : stimulus
        int ph;
        int n;
        logic [31:0] base;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: refill, pop, exact powers, largest class, bad sizes
        send_item(FUNC_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_ALLOC, 32'd16, '0);
        send_item(FUNC_ALLOC, 32'd17, '0);
        send_item(FUNC_ALLOC, 32'd32, '0);
        send_item(FUNC_ALLOC, 32'h0040_0000, '0);
        send_item(FUNC_ALLOC, 32'h0040_0001, '0);
        send_item(FUNC_ALLOC, 32'hFFFF_FFFF, '0);
        // Null free before size check, bad-size free, then fill class 0 to overflow
        send_item(FUNC_FREE, 32'hFFFF_FFFF, '0);
        send_item(FUNC_FREE, 32'h8000_0000, 32'h1234_5670);
        send_item(FUNC_FREE, 32'd16, 32'h0000_0010);
        send_item(FUNC_FREE, 32'd1, 32'h0000_0020);
        send_item(FUNC_FREE, 32'd16, 32'h0000_0030);
        send_item(FUNC_FREE, 32'h0040_0000, 32'hFFFF_FFF0);
        send_item(FUNC_ALLOC, 32'h0040_0000, '0);
        drain_results();

        // Small window at 0 with no header: zero address grant, then out of memory
        set_config(4'd4, 32'h0, 32'h0000_03FF, 13'd0);
        send_item(FUNC_ALLOC, 32'd128, '0);
        send_item(FUNC_ALLOC, 32'd128, '0);
        send_item(FUNC_ALLOC, 32'h0040_0000, '0);
        send_item(FUNC_ALLOC, 32'd512, '0);
        send_item(FUNC_ALLOC, 32'd512, '0);
        drain_results();

        // Bump pointer already past the limit
        set_config(4'd15, 32'hFFFF_FFFF, 32'h0, 13'd4096);
        send_item(FUNC_ALLOC, 32'd1000, '0);
        drain_results();

        // Large span: more blocks than the stack holds, only the lowest kept
        set_config(4'd15, 32'h1000_0000, 32'hFFFF_FFFF, 13'd4096);
        send_item(FUNC_ALLOC, 32'd64, '0);
        send_item(FUNC_ALLOC, 32'd50, '0);
        drain_results();

        // Random phases, each under its own settings
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_config(4'd12, 32'h0000_1000, 32'hFFFF_FFFF, 13'd32);
                1:
                begin
                    base = $urandom & 32'h7FFF_FFF0;
                    set_config(4'd4, base, base + 32'h0002_0000, 13'd0);
                end
                2: set_config(PAGE_W'($urandom_range(12, 4)), 32'hFFF0_0000, 32'hFFFF_FFFF,
                              HDR_W'($urandom_range(4096, 0)));
                default: set_config(PAGE_W'($urandom_range(15, 4)), $urandom, $urandom,
                                    HDR_W'($urandom_range(8191, 0)));
            endcase
            for (n = 0; n < 250; n++)
            begin
                no_idle = (ph == 0 && n < 150);
                if (ph == 1 && n == 100)
                    hold_req = 1'b1;
                if (ph == 2 && n == 125)
                    drain_results();
                random_item();
            end
            drain_results();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/scba_pkg.sv
src/scba_ctrl.sv
src/scba_datapath.sv
src/size_class_block_allocator.sv
tb/sv/scba_result_checker.sv
tb/sv/tb_size_class_block_allocator.sv
